// File: design/day_tagged_bitmask_ring_with_streak_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the day-tagged bitmask ring
// Assertions are compiled for simulation and drop out for synthesis.
// ----------------------------------------------------------------------------
`ifndef DAY_TAGGED_BITMASK_RING_WITH_STREAK_TOP_DEFINES_SVH
`define DAY_TAGGED_BITMASK_RING_WITH_STREAK_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define DTBRS_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dtbrs: invariant violated");

// Checks that a condition implies a consequence in the same cycle.
`define DTBRS_ASSERT_IMPLY(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dtbrs: implication violated");

`else

`define DTBRS_ASSERT_ALWAYS(lbl, expr)
`define DTBRS_ASSERT_IMPLY(lbl, pre, post)

`endif

`endif

// File: design/dtbrs_pkg.sv
// ----------------------------------------------------------------------------
// dtbrs_pkg
// Types, codes and helpers shared by the day-tagged bitmask ring.
// ----------------------------------------------------------------------------
package dtbrs_pkg;

	// Default ring depth.
	localparam int SLOTS_DEF = 64;

	// Field widths on the stream ports.
	localparam int DAY_W     = 32;
	localparam int MASK_W    = 8;
	localparam int ITEM_W    = 3;
	localparam int COUNT_W   = 4;
	localparam int STREAK_W  = 7;
	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 3;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_LOOK   = 2'd0,
		OP_MARK   = 2'd1,
		OP_UNMARK = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_MARKED   = 3'd0,
		STS_ALREADY  = 3'd1,
		STS_UNMARKED = 3'd2,
		STS_NOTHING  = 3'd3,
		STS_LOOK     = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_ADJ,
		ST_CLR,
		ST_READ,
		ST_RMW,
		ST_WALK,
		ST_DONE
	} state_t;

	// One ring entry as stored in memory.
	typedef struct packed {
		logic               valid;
		logic [MASK_W-1:0]  mask;
		logic [DAY_W-1:0]   tag;
	} entry_t;

	// Number of set bits in a mask.
	function automatic logic [COUNT_W-1:0] popcount(input logic [MASK_W-1:0] m);
		logic [COUNT_W-1:0] c;
		c = '0;
		for (int i = 0; i < MASK_W; i++) begin
			c = c + COUNT_W'(m[i]);
		end
		return c;
	endfunction

endpackage

// File: design/day_tagged_bitmask_ring_with_streak_top.sv
// ----------------------------------------------------------------------------
// day_tagged_bitmask_ring_with_streak_top
// Direct-mapped ring of day-tagged 8-bit masks with mark, unmark, look,
// clear all, and a backward streak count over consecutive days.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_ stream: s_tuser carries the operation and s_tdata
// the day and item. Every accepted transfer yields exactly one result transfer
// on the m_ stream: the status code in m_tuser, and mask, popcount,
// streak and the any-recorded flag in m_tdata.
// One request is in work at a time. The ring sits in one single-port-write
// synchronous memory. A request reduces the day modulo SLOTS four bits per
// cycle (ST_MOD), removes the sign bias (ST_ADJ), reads its entry (ST_READ)
// and does the read-modify-write (ST_RMW). The walk back through the ring
// then reads one entry per cycle and stops at the first day that does not
// hold the item, or once the streak reaches SLOTS. A clear-all sweeps the
// memory one entry per cycle. After reset the same sweep runs and s_tready
// stays low until it ends. The result sits in an output register, so a new
// request is accepted while a finished result still waits for m_tready; the
// block then holds in its last step until the register frees.
// ----------------------------------------------------------------------------
`include "day_tagged_bitmask_ring_with_streak_top_defines.svh"

module day_tagged_bitmask_ring_with_streak_top #(
	parameter int SLOTS = dtbrs_pkg::SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Bits from low: day[31:0], item[34:32], zero fill [39:35].
	input  logic [dtbrs_pkg::S_TDATA_W-1:0]   s_tdata,
	// Bits from low: op[1:0].
	input  logic [dtbrs_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Bits from low: day_mask[7:0], day_count[11:8], streak[18:12],
	// any_recorded[19], zero fill [23:20].
	output logic [dtbrs_pkg::M_TDATA_W-1:0]   m_tdata,
	// Bits from low: status[2:0].
	output logic [dtbrs_pkg::M_TUSER_W-1:0]   m_tuser
);

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int TW  = SW + 4;
	localparam int OFS = int'(64'd2147483648 % SLOTS);

	localparam int DW = dtbrs_pkg::DAY_W;
	localparam int MW = dtbrs_pkg::MASK_W;
	localparam int IW = dtbrs_pkg::ITEM_W;

	// Control state.
	dtbrs_pkg::state_t state_q, state_d;
	logic [SW-1:0]     clr_addr_q;
	logic              clr_op_q;
	logic [2:0]        nib_q;
	logic              pend_s1;
	logic              m_tvalid_q;
	logic [CW-1:0]     nz_q;

	// Request and datapath registers.
	dtbrs_pkg::op_t     op_q;
	logic [DW-1:0]      day_q;
	logic [IW-1:0]      item_q;
	logic [DW-1:0]      u_q;
	logic [SW-1:0]      r_q;
	logic [SW-1:0]      slot_q;
	logic [SW-1:0]      wslot_q;
	logic [DW-1:0]      wday_q;
	logic [DW-1:0]      wday_s1;
	logic [CW-1:0]      cnt_q;
	logic [MW-1:0]      res_mask_q;
	dtbrs_pkg::status_t res_status_q;

	// Output register.
	logic [MW-1:0]                 out_mask_q;
	logic [dtbrs_pkg::COUNT_W-1:0] out_count_q;
	logic [dtbrs_pkg::STREAK_W-1:0] out_streak_q;
	logic                          out_any_q;
	dtbrs_pkg::status_t            out_status_q;

	// Memory ports.
	dtbrs_pkg::entry_t mem [SLOTS];
	dtbrs_pkg::entry_t rd_q;
	dtbrs_pkg::entry_t mem_wdata;
	logic              mem_we;
	logic [SW-1:0]     mem_waddr;
	logic [SW-1:0]     rd_addr;

	// Combinational helpers.
	logic [SW-1:0]      mod_next;
	logic [SW-1:0]      slot_adj;
	logic               accept;
	logic               out_load;
	logic               walk_hit;
	logic               walk_done;
	logic               rmw_match;
	logic [MW-1:0]      rmw_cur;
	logic [MW-1:0]      rmw_bit;
	logic [MW-1:0]      rmw_new;
	logic [MW-1:0]      rmw_res;
	logic               rmw_write;
	dtbrs_pkg::status_t rmw_status;

	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == dtbrs_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	// One step of the day reduction: append four bits, then fold back below SLOTS.
	always_comb begin
		logic [TW-1:0] t;
		t = {r_q, u_q[DW-1 -: 4]};
		for (int k = 3; k >= 0; k--) begin
			if (t >= (TW'(SLOTS) << k)) begin
				t = t - (TW'(SLOTS) << k);
			end
		end
		mod_next = SW'(t);
	end

	// Undo the bias added to make the day unsigned.
	always_comb begin
		if (r_q >= SW'(OFS)) begin
			slot_adj = r_q - SW'(OFS);
		end else begin
			slot_adj = SW'((SW+1)'(r_q) + (SW+1)'(SLOTS - OFS));
		end
	end

	// Read-modify-write decision for the selected entry.
	always_comb begin
		rmw_match  = rd_q.valid && (rd_q.tag == day_q);
		rmw_cur    = rmw_match ? rd_q.mask : '0;
		rmw_bit    = MW'(1) << item_q;
		rmw_new    = rmw_cur;
		rmw_res    = rmw_cur;
		rmw_write  = 1'b0;
		rmw_status = dtbrs_pkg::STS_LOOK;
		unique case (op_q)
			dtbrs_pkg::OP_MARK: begin
				rmw_write = 1'b1;
				if ((rmw_cur & rmw_bit) != '0) begin
					rmw_status = dtbrs_pkg::STS_ALREADY;
				end else begin
					rmw_new    = rmw_cur | rmw_bit;
					rmw_status = dtbrs_pkg::STS_MARKED;
				end
				rmw_res = rmw_new;
			end
			dtbrs_pkg::OP_UNMARK: begin
				if ((rmw_cur & rmw_bit) != '0) begin
					rmw_write  = 1'b1;
					rmw_new    = rmw_cur & ~rmw_bit;
					rmw_status = dtbrs_pkg::STS_UNMARKED;
				end else begin
					rmw_status = dtbrs_pkg::STS_NOTHING;
				end
				rmw_res = rmw_new;
			end
			dtbrs_pkg::OP_LOOK,
			dtbrs_pkg::OP_CLEAR: begin
				rmw_status = dtbrs_pkg::STS_LOOK;
			end
		endcase
	end

	// Streak walk: a returned entry extends the streak when it holds the item.
	assign walk_hit  = rd_q.valid && (rd_q.tag == wday_s1) && rd_q.mask[item_q];
	assign walk_done = pend_s1 && (!walk_hit || (cnt_q == CW'(SLOTS - 1)));

	// Next state, memory port control and handshake.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = slot_q;
		mem_wdata = '{valid: 1'b1, mask: rmw_new, tag: day_q};
		rd_addr   = slot_q;
		s_tready  = 1'b0;
		unique case (state_q)
			dtbrs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = dtbrs_pkg::ST_MOD;
				end
			end
			dtbrs_pkg::ST_MOD: begin
				if (nib_q == 3'd7) begin
					state_d = dtbrs_pkg::ST_ADJ;
				end
			end
			dtbrs_pkg::ST_ADJ: begin
				state_d = (op_q == dtbrs_pkg::OP_CLEAR) ? dtbrs_pkg::ST_CLR
					: dtbrs_pkg::ST_READ;
			end
			dtbrs_pkg::ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '{valid: 1'b0, mask: '0, tag: '0};
				if (clr_addr_q == SW'(SLOTS - 1)) begin
					state_d = clr_op_q ? dtbrs_pkg::ST_DONE : dtbrs_pkg::ST_IDLE;
				end
			end
			dtbrs_pkg::ST_READ: begin
				state_d = dtbrs_pkg::ST_RMW;
			end
			dtbrs_pkg::ST_RMW: begin
				mem_we  = rmw_write;
				state_d = dtbrs_pkg::ST_WALK;
			end
			dtbrs_pkg::ST_WALK: begin
				rd_addr = wslot_q;
				if (walk_done) begin
					state_d = dtbrs_pkg::ST_DONE;
				end
			end
			dtbrs_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = dtbrs_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Ring memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[rd_addr];
	end

	// Control registers; reset starts the clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtbrs_pkg::ST_CLR;
			clr_addr_q <= '0;
			clr_op_q   <= 1'b0;
			nib_q      <= '0;
			pend_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
			nz_q       <= '0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == dtbrs_pkg::ST_WALK) && !walk_done;

			if (accept) begin
				nib_q <= '0;
			end else if (state_q == dtbrs_pkg::ST_MOD) begin
				nib_q <= nib_q + 3'd1;
			end

			if (state_q == dtbrs_pkg::ST_ADJ) begin
				clr_addr_q <= '0;
				clr_op_q   <= 1'b1;
			end else if (state_q == dtbrs_pkg::ST_CLR) begin
				clr_addr_q <= clr_addr_q + SW'(1);
			end

			// Count of entries with a nonzero mask.
			if (state_q == dtbrs_pkg::ST_CLR) begin
				nz_q <= '0;
			end else if (state_q == dtbrs_pkg::ST_RMW && rmw_write) begin
				if (rmw_new != '0 && rd_q.mask == '0) begin
					nz_q <= nz_q + CW'(1);
				end else if (rmw_new == '0 && rd_q.mask != '0) begin
					nz_q <= nz_q - CW'(1);
				end
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Request capture, day reduction, update results and streak walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= dtbrs_pkg::op_t'(s_tuser);
			day_q  <= s_tdata[DW-1:0];
			item_q <= s_tdata[DW +: IW];
			u_q    <= s_tdata[DW-1:0] ^ {1'b1, {(DW-1){1'b0}}};
			r_q    <= '0;
		end
		if (state_q == dtbrs_pkg::ST_MOD) begin
			r_q <= mod_next;
			u_q <= u_q << 4;
		end
		if (state_q == dtbrs_pkg::ST_ADJ) begin
			slot_q <= slot_adj;
		end
		if (state_q == dtbrs_pkg::ST_CLR) begin
			res_mask_q   <= '0;
			res_status_q <= dtbrs_pkg::STS_LOOK;
			cnt_q        <= '0;
		end
		if (state_q == dtbrs_pkg::ST_RMW) begin
			res_mask_q   <= rmw_res;
			res_status_q <= rmw_status;
			cnt_q        <= CW'(rmw_res[item_q]);
			wday_q       <= day_q - DW'(1);
			wslot_q      <= (slot_q == '0) ? SW'(SLOTS - 1) : slot_q - SW'(1);
		end
		if (state_q == dtbrs_pkg::ST_WALK) begin
			wday_s1 <= wday_q;
			wday_q  <= wday_q - DW'(1);
			wslot_q <= (wslot_q == '0) ? SW'(SLOTS - 1) : wslot_q - SW'(1);
			if (pend_s1 && walk_hit) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
		if (out_load) begin
			out_mask_q   <= res_mask_q;
			out_count_q  <= dtbrs_pkg::popcount(res_mask_q);
			out_streak_q <= dtbrs_pkg::STREAK_W'(cnt_q);
			out_any_q    <= (nz_q != '0);
			out_status_q <= res_status_q;
		end
	end

	// Output stream.
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {4'b0000, out_any_q, out_streak_q, out_count_q, out_mask_q};

	// Checks on the sequencer and the bookkeeping.
	`DTBRS_ASSERT_ALWAYS(a_nz_range, nz_q <= CW'(SLOTS))
	`DTBRS_ASSERT_IMPLY(a_slot_range, state_q == dtbrs_pkg::ST_READ, slot_q <= SW'(SLOTS - 1))
	`DTBRS_ASSERT_IMPLY(a_walk_cap, state_q == dtbrs_pkg::ST_WALK, cnt_q < CW'(SLOTS))
	`DTBRS_ASSERT_IMPLY(a_we_state, mem_we, state_q == dtbrs_pkg::ST_RMW || state_q == dtbrs_pkg::ST_CLR)

endmodule
